// File: hdl/hufd_pkg.sv
`default_nettype none

package hufd_pkg;

  localparam int NODE_W           = 9;
  localparam int SYM_W            = 8;
  localparam int NODE_COUNT_DEF   = 511;
  localparam int SYMBOL_COUNT_DEF = 256;

  localparam int OP_W        = 2;
  localparam int CNT_W       = 4;
  localparam int IN_W        = 50;
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 8;
  localparam int M_TUSER_W   = 1;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_DECODE  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // one table entry, leaf flag in the lowest bit
  typedef struct packed {
    logic              right_valid;
    logic [NODE_W-1:0] right_child;
    logic              left_valid;
    logic [NODE_W-1:0] left_child;
    logic [SYM_W-1:0]  symbol;
    logic              is_leaf;
  } node_t;

  // input beat payload, node_index in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]  bit_count;
    logic [7:0]        data_byte;
    logic              right_valid;
    logic [NODE_W-1:0] right_child;
    logic              left_valid;
    logic [NODE_W-1:0] left_child;
    logic [SYM_W-1:0]  node_symbol;
    logic              node_is_leaf;
    logic [NODE_W-1:0] node_index;
  } in_t;

endpackage

`default_nettype wire

// File: hdl/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder.
// Input stream (s_*): tuser carries the operation (load node, decode byte,
// restart walk); tdata carries the node fields for a load and the byte plus
// its valid-bit count for a decode. One beat is taken at a time.
// Output stream (m_*): one beat per decoded symbol or per walk error;
// tuser is the error flag, tlast marks the final result of a decode byte.
// cfg_we/cfg_wdata write the root node index; write only while idle.
// A decode walks one bit per step, spends an extra step on each symbol
// found at a leaf, then passes the flush state on its way back to idle.
// Each step waits on the registered read of the node table, since the
// next address is a field of the node just read.
// The walk position persists across decode beats.
// Reset clears the walk to node 0, the root register to 0 and the output;
// the node table is not cleared and must be loaded before decoding.
// A stalled receiver holds the walk once a second result is waiting; the
// last result of a byte sits in the output register while the next input
// beat is taken.
`default_nettype none

module huffman_tree_walk_decoder #(
  parameter int SYMBOL_COUNT = hufd_pkg::SYMBOL_COUNT_DEF,
  parameter int NODE_COUNT   = hufd_pkg::NODE_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // node_index, node_is_leaf, node_symbol, left_child, left_valid,
  // right_child, right_valid, data_byte, bit_count, zero pad
  input  wire logic [hufd_pkg::S_TDATA_W-1:0]   s_tdata,
  // operation
  input  wire logic [hufd_pkg::OP_W-1:0]        s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // symbol
  output logic [hufd_pkg::M_TDATA_W-1:0]        m_tdata,
  // error
  output logic [hufd_pkg::M_TUSER_W-1:0]        m_tuser,
  output logic                                  m_tlast,
  input  wire logic                             cfg_we,
  input  wire logic [hufd_pkg::NODE_W-1:0]      cfg_wdata
);
  import hufd_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [NODE_W-1:0] NODE_LIM = NODE_W'(NODE_COUNT);
  localparam logic [SYM_W:0]    SYM_LIM  = (SYM_W+1)'(SYMBOL_COUNT);
  localparam logic [SYM_W-1:0]  SYM_MAX  = SYM_W'(SYMBOL_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t            state;
  logic [NODE_W-1:0] root_node;
  logic [NODE_W-1:0] pos;
  logic [7:0]        byte_sh;
  logic [CNT_W-1:0]  bits_left;
  logic              arrived;
  logic              pend_valid;
  logic [SYM_W-1:0]  pend_sym;
  logic              pend_err;

  node_t             mem [NODE_COUNT];
  node_t             rd_q;
  logic              rd_oob;

  in_t               in;
  logic              accept;
  logic [CNT_W-1:0]  cnt_sat;
  node_t             cur;
  node_t             wr_node;
  logic              out_free;
  logic              step_bit;
  logic [NODE_W-1:0] child;
  logic              child_ok;
  logic              ren;
  logic [NODE_W-1:0] raddr;
  logic              res_go;
  logic [SYM_W-1:0]  res_sym;
  logic              res_err;
  logic              take_bit;
  logic              go_flush;
  logic              go_root;
  logic              go_child;
  logic              stall;
  logic              push_walk;
  logic              push_flush;

  assign in       = in_t'(s_tdata[IN_W-1:0]);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cnt_sat  = (in.bit_count > BITS_PER_BYTE) ? BITS_PER_BYTE : in.bit_count;
  assign cur      = rd_oob ? '0 : rd_q;
  assign out_free = !m_tvalid || m_tready;
  assign step_bit = byte_sh[7];
  assign child    = step_bit ? cur.right_child : cur.left_child;
  assign child_ok = (step_bit ? cur.right_valid : cur.left_valid) && (child < NODE_LIM);

  always_comb begin
    wr_node              = '0;
    wr_node.is_leaf      = in.node_is_leaf;
    wr_node.symbol       = ({1'b0, in.node_symbol} >= SYM_LIM) ? SYM_MAX : in.node_symbol;
    wr_node.left_child   = in.left_child;
    wr_node.left_valid   = in.left_valid;
    wr_node.right_child  = in.right_child;
    wr_node.right_valid  = in.right_valid;
  end

  always_comb begin
    res_go   = 1'b0;
    res_sym  = '0;
    res_err  = 1'b0;
    take_bit = 1'b0;
    go_flush = 1'b0;
    go_root  = 1'b0;
    go_child = 1'b0;
    case (state)
      ST_WALK: begin
        if (arrived && cur.is_leaf) begin
          res_go  = 1'b1;
          res_sym = cur.symbol;
          go_root = 1'b1;
        end else if (bits_left == '0) begin
          go_flush = 1'b1;
        end else begin
          take_bit = 1'b1;
          if (child_ok) begin
            go_child = 1'b1;
          end else begin
            res_go  = 1'b1;
            res_err = 1'b1;
            go_root = 1'b1;
          end
        end
      end
      default: ;
    endcase
    stall      = res_go && pend_valid && !out_free;
    push_walk  = res_go && pend_valid && !stall;
    push_flush = (state == ST_FLUSH) && pend_valid && out_free;
    ren   = 1'b0;
    raddr = pos;
    if (accept && s_tuser == OP_DECODE && cnt_sat != '0) begin
      ren = 1'b1;
    end else if (go_root && !stall) begin
      ren   = 1'b1;
      raddr = root_node;
    end else if (go_child) begin
      ren   = 1'b1;
      raddr = child;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      root_node  <= '0;
      pos        <= '0;
      bits_left  <= '0;
      arrived    <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        root_node <= cfg_wdata;
      end
      if (push_walk || push_flush) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (s_tuser)
              OP_RESTART: pos <= root_node;
              OP_DECODE: begin
                if (cnt_sat != '0) begin
                  bits_left <= cnt_sat;
                  arrived   <= 1'b0;
                  state     <= ST_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (!stall) begin
            if (go_flush) begin
              state <= ST_FLUSH;
            end
            if (take_bit) begin
              bits_left <= bits_left - 1'b1;
            end
            if (go_root) begin
              pos     <= root_node;
              arrived <= 1'b0;
            end
            if (go_child) begin
              pos     <= child;
              arrived <= 1'b1;
            end
            if (res_go) begin
              pend_valid <= 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload, table and read port
  always_ff @(posedge clk) begin
    if (accept && s_tuser == OP_LOAD && in.node_index < NODE_LIM) begin
      mem[in.node_index[AW-1:0]] <= wr_node;
    end
    if (ren) begin
      rd_q   <= mem[raddr[AW-1:0]];
      rd_oob <= (raddr >= NODE_LIM);
    end
    if (accept && s_tuser == OP_DECODE) begin
      byte_sh <= in.data_byte;
    end else if (take_bit && !stall) begin
      byte_sh <= {byte_sh[6:0], 1'b0};
    end
    if (res_go && !stall) begin
      pend_sym <= res_sym;
      pend_err <= res_err;
    end
    if (push_walk || push_flush) begin
      m_tdata <= pend_sym;
      m_tuser <= pend_err;
      m_tlast <= push_flush;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hufd_checker.sv
`default_nettype none

module hufd_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic [hufd_pkg::S_TDATA_W-1:0] s_tdata,
  input wire logic [hufd_pkg::OP_W-1:0]      s_tuser,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [hufd_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [hufd_pkg::M_TUSER_W-1:0] m_tuser,
  input wire logic                           m_tlast
);
  import hufd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("error beat with nonzero symbol");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser != OP_DECODE && !m_tvalid |=> !m_tvalid)
    else $error("result from load or restart");

  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_DECODE && s_tdata[49:46] != '0
      |=> !s_tready)
    else $error("decode beat did not start a walk");

endmodule

bind huffman_tree_walk_decoder hufd_checker u_hufd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: test/tb_huffman_tree_walk_decoder.sv
module tb_huffman_tree_walk_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hufd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [OP_W-1:0] op;
    in_t             fields;
  } hufd_cmd_t;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             error;
    logic             last;
  } symbol_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic [OP_W-1:0]        s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic [M_TUSER_W-1:0]   m_tuser;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  logic [NODE_W-1:0]      cfg_wdata = '0;

  huffman_tree_walk_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // pending commands and expected decoder output
  hufd_cmd_t    cmd_queue[$];
  symbol_beat_t expected_symbols[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           decode_beats = 0;
  int           cmd_total = 0;
  logic         hold_off = 1'b0;

  // shadow of the decoder
  node_t             node_table [NODE_COUNT_DEF];
  logic [NODE_W-1:0] walk_pos = '0;
  logic [NODE_W-1:0] root_reg = '0;

  // stimulus-side bookkeeping of which table entries hold a node
  bit tree_loaded [NODE_COUNT_DEF];
  int loaded_ids[$];

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) calm = $urandom_range(10, 40);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic node_t fetch_node(logic [NODE_W-1:0] idx);
    if (idx < NODE_COUNT_DEF) return node_table[idx];
    return '0;
  endfunction

  task automatic walk_tree(input logic [OP_W-1:0] op, input in_t b);
    node_t             nd;
    node_t             cur;
    node_t             nx;
    logic [NODE_W-1:0] child;
    logic              ok;
    int                cnt;
    symbol_beat_t      res;
    symbol_beat_t      got[$];
    case (op)
      OP_LOAD: begin
        if (b.node_index < NODE_COUNT_DEF) begin
          nd.is_leaf     = b.node_is_leaf;
          nd.symbol      = b.node_symbol;
          nd.left_child  = b.left_child;
          nd.left_valid  = b.left_valid;
          nd.right_child = b.right_child;
          nd.right_valid = b.right_valid;
          node_table[b.node_index] = nd;
        end
      end
      OP_RESTART: begin
        walk_pos = root_reg;
      end
      OP_DECODE: begin
        cnt = (b.bit_count > BITS_PER_BYTE) ? int'(BITS_PER_BYTE) : int'(b.bit_count);
        for (int i = 0; i < cnt; i++) begin
          cur = fetch_node(walk_pos);
          if (b.data_byte[7-i]) begin
            child = cur.right_child;
            ok    = cur.right_valid;
          end else begin
            child = cur.left_child;
            ok    = cur.left_valid;
          end
          if (!ok || child >= NODE_COUNT_DEF) begin
            res.symbol = '0;
            res.error  = 1'b1;
            res.last   = 1'b0;
            got.push_back(res);
            walk_pos = root_reg;
          end else begin
            walk_pos = child;
            nx = fetch_node(child);
            if (nx.is_leaf) begin
              res.symbol = nx.symbol;
              res.error  = 1'b0;
              res.last   = 1'b0;
              got.push_back(res);
              walk_pos = root_reg;
            end
          end
        end
        if (got.size() > 0) got[got.size()-1].last = 1'b1;
        foreach (got[j]) expected_symbols.push_back(got[j]);
      end
      default: ;
    endcase
  endtask

  task automatic check_result(input logic [SYM_W-1:0] sym, input logic err, input logic lst);
    symbol_beat_t want;
    if (expected_symbols.size() == 0) begin
      fail_count++;
      if (fail_count < 50)
        $display("%0t unexpected beat: sym %02h err %0b last %0b", $time, sym, err, lst);
    end else begin
      want = expected_symbols.pop_front();
      if (want.symbol !== sym || want.error !== err || want.last !== lst) begin
        fail_count++;
        if (fail_count < 50)
          $display("%0t mismatch: expected sym %02h err %0b last %0b, got sym %02h err %0b last %0b",
                   $time, want.symbol, want.error, want.last, sym, err, lst);
      end
    end
  endtask

  // input side
  int        tx_gap = 0;
  int        tx_calm = 0;
  hufd_cmd_t tx_cmd;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        walk_tree(s_tuser, s_tdata[IN_W-1:0]);
        if (s_tuser == OP_DECODE) decode_beats++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          tx_cmd = cmd_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= tx_cmd.op;
          s_tdata  <= S_TDATA_W'(tx_cmd.fields);
          tx_gap = idle_len(tx_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side
  int rx_stall = 0;
  int rx_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata, m_tuser[0], m_tlast);
      if (rx_stall > 0)
        rx_stall--;
      else if ((m_tvalid && m_tready) || $urandom_range(0, 15) == 0)
        rx_stall = idle_len(rx_calm);
      m_tready <= (rx_stall == 0) && !hold_off;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // long receiver hold while decodes keep coming, so the input backs up
  initial begin
    while (!(decode_beats >= 60 && cmd_queue.size() > 10)) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic push_cmd(input logic [OP_W-1:0] op, input in_t f);
    hufd_cmd_t c;
    c.op = op;
    c.fields = f;
    cmd_queue.push_back(c);
    cmd_total++;
  endtask

  function automatic in_t random_fields();
    logic [63:0] r;
    in_t         f;
    r = {$urandom, $urandom};
    f = r[IN_W-1:0];
    return f;
  endfunction

  task automatic push_load(input int idx, input bit leaf, input int sym,
                           input int l, input bit lv, input int r, input bit rv);
    in_t f;
    f = random_fields();
    f.node_index   = NODE_W'(idx);
    f.node_is_leaf = leaf;
    f.node_symbol  = SYM_W'(sym);
    f.left_child   = NODE_W'(l);
    f.left_valid   = lv;
    f.right_child  = NODE_W'(r);
    f.right_valid  = rv;
    push_cmd(OP_LOAD, f);
    if (idx < NODE_COUNT_DEF && !tree_loaded[idx]) begin
      tree_loaded[idx] = 1'b1;
      loaded_ids.push_back(idx);
    end
  endtask

  task automatic push_decode(input int data, input int cnt);
    in_t f;
    f = random_fields();
    f.data_byte = 8'(data);
    f.bit_count = CNT_W'(cnt);
    push_cmd(OP_DECODE, f);
  endtask

  // valid children only point at entries already holding a node, or past the table
  function automatic int pick_child(output bit vld);
    vld = $urandom_range(0, 1);
    if (!vld) return $urandom_range(0, NODE_COUNT_DEF - 1);
    if ($urandom_range(0, 7) == 0) return NODE_COUNT_DEF;
    return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
  endfunction

  task automatic push_stray_load();
    int l;
    int r;
    bit lv;
    bit rv;
    l = pick_child(lv);
    r = pick_child(rv);
    push_load($urandom_range(0, NODE_COUNT_DEF), $urandom_range(0, 1),
              $urandom_range(0, 255), l, lv, r, rv);
  endtask

  // code tree with k leaves, built bottom up by pairing random subtrees
  task automatic plant_tree(input int k, input int root);
    bit taken [NODE_COUNT_DEF];
    int ids[$];
    int pool[$];
    int idx;
    int a;
    int na;
    int nb;
    bit lv;
    bit rv;
    taken[root] = 1'b1;
    while (ids.size() < 2 * k - 2) begin
      idx = $urandom_range(0, NODE_COUNT_DEF - 1);
      if (!taken[idx]) begin
        taken[idx] = 1'b1;
        ids.push_back(idx);
      end
    end
    ids.push_back(root);
    for (int i = 0; i < k; i++) begin
      if (k == 1 && $urandom_range(0, 1))
        push_load(ids[i], 1'b1, $urandom_range(0, 255), root, 1'b1, root, $urandom_range(0, 1));
      else
        push_load(ids[i], 1'b1, $urandom_range(0, 255), $urandom_range(0, NODE_COUNT_DEF - 1),
                  1'b0, $urandom_range(0, NODE_COUNT_DEF - 1), 1'b0);
      pool.push_back(ids[i]);
    end
    for (int i = k; i < 2 * k - 1; i++) begin
      a = $urandom_range(0, pool.size() - 1);
      na = pool[a];
      pool.delete(a);
      a = $urandom_range(0, pool.size() - 1);
      nb = pool[a];
      pool.delete(a);
      lv = 1'b1;
      rv = 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) lv = 1'b0;
        else rv = 1'b0;
      end
      push_load(ids[i], 1'b0, $urandom_range(0, 255), na, lv, nb, rv);
      pool.push_back(ids[i]);
    end
  endtask

  task automatic wait_drained();
    while (!(cmd_queue.size() == 0 && !s_tvalid && expected_symbols.size() == 0))
      @(posedge clk);
  endtask

  task automatic set_root(input int v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= NODE_W'(v);
    root_reg = NODE_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int   phase;
    int   k;
    int   root;
    int   n;
    int   r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // small hand-built tree rooted at 0, leaves 0x00 / 0xFF / 0xA5
    set_root(0);
    push_load(0, 1'b0, 8'h3C, 1, 1'b1, NODE_COUNT_DEF - 1, 1'b1);
    push_load(1, 1'b1, 8'h00, 0, 1'b0, 0, 1'b0);
    push_load(NODE_COUNT_DEF - 1, 1'b0, 8'h00, 2, 1'b1, 3, 1'b1);
    push_load(2, 1'b1, 8'hFF, 510, 1'b0, 510, 1'b0);
    push_load(3, 1'b1, 8'hA5, NODE_COUNT_DEF, 1'b1, NODE_COUNT_DEF - 1, 1'b1);
    push_load(4, 1'b0, 8'h5A, NODE_COUNT_DEF, 1'b1, 1, 1'b1);
    push_load(5, 1'b0, 8'h81, 0, 1'b0, 0, 1'b0);
    push_load(NODE_COUNT_DEF, 1'b1, 8'h77, 0, 1'b1, 0, 1'b1);
    push_decode(8'h00, 8);
    push_decode(8'hFF, 8);
    push_decode(8'h80, 1);
    push_decode(8'h5A, 8);
    push_decode(8'h3C, 0);
    push_decode(8'hC3, 15);
    push_cmd(OP_UNUSED, random_fields());
    push_decode(8'hF0, 4);
    push_cmd(OP_RESTART, random_fields());
    push_decode(8'h80, 1);
    push_cmd(OP_RESTART, random_fields());
    push_decode(8'hC0, 2);
    push_decode(8'h80, 1);
    // root moves while the walk sits mid-code
    set_root(4);
    push_decode(8'h00, 2);
    push_decode(8'h40, 3);
    set_root(5);
    push_cmd(OP_RESTART, random_fields());
    push_decode(8'hA5, 8);
    set_root(NODE_COUNT_DEF - 1);
    push_cmd(OP_RESTART, random_fields());
    push_decode(8'h7E, 8);

    phase = 0;
    while (cmd_total < 430) begin
      if (phase == 0) k = 1;
      else if ($urandom_range(0, 9) == 0) k = 1;
      else k = $urandom_range(2, 24);
      if (phase == 1) root = NODE_COUNT_DEF - 1;
      else if (phase == 2) root = 0;
      else root = $urandom_range(0, NODE_COUNT_DEF - 1);
      set_root(root);
      plant_tree(k, root);
      if ($urandom_range(0, 3) != 0) push_cmd(OP_RESTART, random_fields());
      n = $urandom_range(10, 30);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 80) push_decode($urandom_range(0, 255), 8);
        else if (r < 88) push_decode($urandom_range(0, 255), $urandom_range(1, 7));
        else if (r < 92) push_stray_load();
        else if (r < 95) push_cmd(OP_RESTART, random_fields());
        else if (r < 97) push_cmd(OP_UNUSED, random_fields());
        else if (r < 99) push_decode($urandom_range(0, 255), 0);
        else push_decode($urandom_range(0, 255), $urandom_range(9, 15));
      end
      push_decode($urandom_range(0, 255), $urandom_range(1, 8));
      phase++;
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
hdl/hufd_pkg.sv
hdl/huffman_tree_walk_decoder.sv
hdl/hufd_checker.sv
test/tb_huffman_tree_walk_decoder.sv
